// ----- rtl/sibv_pkg.sv -----
// Shared types and constants for the sparse index to bit vector builder.
package sibv_pkg;

    // Field widths of the input and result items.
    localparam int unsigned POS_W     = 32;
    localparam int unsigned WIDX_W    = 8;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned WORD_W    = 64;
    // Bit select within a word (the low six bits of a difference).
    localparam int unsigned BIT_W     = 6;
    // Word number bits of a non-negative 32-bit difference.
    localparam int unsigned DWORD_W   = POS_W - 1 - BIT_W;
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = WIDX_W + WORD_W;

    // Operation codes carried by an input item.
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_SET   = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    // One result item.
    typedef struct packed {
        logic [WORD_W-1:0] word_value;
        logic [WIDX_W-1:0] word_index_out;
    } out_item_t;

    // Push request from the word stage into the result queue.
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } out_push_t;

endpackage

// ----- rtl/sparse_index_to_bit_vector.sv -----
// Top level of the sparse index to bit vector builder.
//
// The block keeps WORDS words of 64 bits in one RAM and takes one item per cycle for set and read
// operations when not stalled by a clearing pass or a full result queue: a set subtracts
// position_offset from the position and ORs bit (d & 63) into word (d >> 6), skipping negative
// or out-of-range differences; a read returns one word (zero beyond the vector) through the word
// stage register and a two-entry result queue. Each set is a read-modify-write of one word
// through the RAM's read and write ports, with the last write bypassed so that back-to-back sets
// to the same word see each other. A clear, and reset itself, run a pass that writes zero to
// every word, one word per cycle over the single write port; s_tready stays low until it ends.
// cfg_wr_en is taken at any edge and should only be used while the block is idle.
module sparse_index_to_bit_vector #(
    parameter int unsigned WORDS = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration: position_offset.
    input  logic                              cfg_wr_en,
    input  logic [sibv_pkg::POS_W-1:0]        cfg_wr_data,
    // Input items.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [1:0] op, [33:2] position, [41:34] word_index, [47:42] zero
    input  logic [sibv_pkg::S_TDATA_W-1:0]    s_tdata,
    // Result items.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] word_index_out, [71:8] word_value
    output logic [sibv_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int unsigned AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [sibv_pkg::DWORD_W-1:0] WORDS_W = sibv_pkg::DWORD_W'(WORDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);

    // Input field decode.
    sibv_pkg::op_t                  in_op;
    logic [sibv_pkg::POS_W-1:0]     in_pos;
    logic [sibv_pkg::WIDX_W-1:0]    in_widx;
    logic [sibv_pkg::POS_W-1:0]     diff;
    logic [sibv_pkg::DWORD_W-1:0]   widx_ext;
    logic                           set_hit;
    logic                           read_hit;
    logic [AW-1:0]                  in_addr;
    logic                           accept;

    // Configuration register.
    logic [sibv_pkg::POS_W-1:0]     position_offset_reg;

    // Word stage registers.
    logic                           a_valid_reg;
    sibv_pkg::op_t                  a_op_reg;
    logic [AW-1:0]                  a_addr_reg;
    logic [sibv_pkg::BIT_W-1:0]     a_bit_reg;
    logic                           a_hit_reg;
    logic [sibv_pkg::WIDX_W-1:0]    a_widx_reg;

    // Clearing pass.
    logic                           clr_active_reg;
    logic [AW-1:0]                  clr_addr_reg;

    // RAM ports and write bypass.
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [sibv_pkg::WORD_W-1:0]    ram_wdata;
    logic [sibv_pkg::WORD_W-1:0]    ram_rdata;
    logic                           fwd_valid_reg;
    logic [AW-1:0]                  fwd_addr_reg;
    logic [sibv_pkg::WORD_W-1:0]    fwd_data_reg;
    logic [sibv_pkg::WORD_W-1:0]    cur_word;

    // Result queue.
    sibv_pkg::out_push_t            push;
    sibv_pkg::out_item_t            m_item;
    logic [1:0]                     q_count;
    logic [1:0]                     occ_after;
    logic                           a_is_clear;

    assign in_op    = sibv_pkg::op_t'(s_tdata[1:0]);
    assign in_pos   = s_tdata[33:2];
    assign in_widx  = s_tdata[41:34];
    assign widx_ext = sibv_pkg::DWORD_W'(in_widx);

    // Map the position to a word and check the range.
    always_comb begin
        diff     = in_pos - position_offset_reg;
        set_hit  = !diff[sibv_pkg::POS_W-1] &&
                   (diff[sibv_pkg::POS_W-2:sibv_pkg::BIT_W] < WORDS_W);
        read_hit = (widx_ext < WORDS_W);
        if (in_op == sibv_pkg::OP_SET) begin
            in_addr = AW'(diff[sibv_pkg::POS_W-2:sibv_pkg::BIT_W]);
        end else begin
            in_addr = AW'(widx_ext);
        end
    end

    // Accept only when the item can reach the queue and no clear is pending.
    assign a_is_clear = a_valid_reg && (a_op_reg == sibv_pkg::OP_CLEAR);
    assign occ_after  = q_count + 2'(push.valid) - 2'(m_tvalid && m_tready);
    assign s_tready   = !clr_active_reg && !a_is_clear && (occ_after <= 2'd1);
    assign accept     = s_tvalid && s_tready;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_offset_reg <= '0;
        end else if (cfg_wr_en) begin
            position_offset_reg <= cfg_wr_data;
        end
    end

    // Word stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= accept;
        end
    end

    // Word stage payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_op_reg   <= in_op;
            a_addr_reg <= in_addr;
            a_bit_reg  <= diff[sibv_pkg::BIT_W-1:0];
            a_hit_reg  <= (in_op == sibv_pkg::OP_SET) ? set_hit : read_hit;
            a_widx_reg <= in_widx;
        end
    end

    // Clearing pass: starts at reset and after a clear reaches the word stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (a_is_clear) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            if (clr_addr_reg == LAST_ADDR) begin
                clr_active_reg <= 1'b0;
            end else begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    // Current word: the last write bypasses the RAM's old read data.
    assign cur_word = (fwd_valid_reg && (fwd_addr_reg == a_addr_reg)) ? fwd_data_reg : ram_rdata;

    // RAM write port: clearing pass or set.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = a_addr_reg;
        ram_wdata = cur_word | (sibv_pkg::WORD_W'(1) << a_bit_reg);
        if (clr_active_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else if (a_valid_reg && (a_op_reg == sibv_pkg::OP_SET) && a_hit_reg) begin
            ram_we = 1'b1;
        end
    end

    // Remember the last write for the bypass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else begin
            fwd_valid_reg <= ram_we;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_addr_reg <= ram_waddr;
        fwd_data_reg <= ram_wdata;
    end

    sibv_ram #(
        .WIDTH (sibv_pkg::WORD_W),
        .DEPTH (WORDS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // Read results go to the queue.
    always_comb begin
        push.valid               = a_valid_reg && (a_op_reg == sibv_pkg::OP_READ);
        push.item.word_index_out = a_widx_reg;
        push.item.word_value     = a_hit_reg ? cur_word : '0;
    end

    sibv_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .count   (q_count),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_item  (m_item)
    );

    assign m_tdata = {m_item.word_value, m_item.word_index_out};

    // No item enters while the clearing pass runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !accept)
        else $error("item accepted during clearing pass");

    // The queue never receives a result while full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> (q_count != 2'd2))
        else $error("result pushed into a full queue");

    // An accepted clear starts the clearing pass once it has passed through the word stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_op == sibv_pkg::OP_CLEAR)) |=> ##1 clr_active_reg)
        else $error("clear did not start the clearing pass");

    // A set never writes the RAM while the pass is running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !(a_valid_reg && (a_op_reg == sibv_pkg::OP_SET)))
        else $error("set in word stage during clearing pass");

endmodule

// ----- rtl/sibv_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module sibv_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 256
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read in one block; a read of the address being written sees the old word.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/sibv_outq.sv -----
// Two-entry result queue that decouples the word stage from the result channel.
module sibv_outq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sibv_pkg::out_push_t   push,
    output logic [1:0]            count,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sibv_pkg::out_item_t   m_item
);

    sibv_pkg::out_item_t ent_reg [2];
    logic                rd_ptr_reg;
    logic [1:0]          count_reg;
    logic [1:0]          count_next;
    logic                wr_ptr;
    logic                pop;

    assign pop     = m_valid && m_ready;
    assign wr_ptr  = rd_ptr_reg ^ count_reg[0];
    assign m_valid = (count_reg != 2'd0);
    assign m_item  = ent_reg[rd_ptr_reg];
    assign count   = count_reg;

    // Occupancy after this edge.
    always_comb begin
        count_next = count_reg + 2'(push.valid) - 2'(pop);
    end

    // Control state of the queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push.valid) begin
            ent_reg[wr_ptr] <= push.item;
        end
    end

endmodule
